// ===== hdl/mbalu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbalu_pkg: shared types and constants of the multibyte ALU
// Beat payload structs, function codes and datapath width constants.
// ----------------------------------------------------------------------------
package mbalu_pkg;

	// datapath width in bytes (1..8); port fields stay 64 bits wide
	localparam int WIDTH_BYTES = 8;
	localparam int VBITS       = WIDTH_BYTES * 8;
	localparam int DATA_W      = 64;
	localparam int FUNC_W      = 2;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_ADC = 2'd0;  // add with carry
	localparam logic [FUNC_W-1:0] FUNC_SBC = 2'd1;  // subtract with borrow
	localparam logic [FUNC_W-1:0] FUNC_RCR = 2'd2;  // rotate right through carry
	localparam logic [FUNC_W-1:0] FUNC_RCL = 2'd3;  // rotate left through carry

	// most negative value, used as the signed sentinel
	localparam logic [VBITS-1:0] SENTINEL = {1'b1, {(VBITS-1){1'b0}}};

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_value;
		logic              carry_out;
		logic              special;
		logic              negative_fill;
	} out_beat_t;

endpackage

// ===== hdl/mbalu_core.sv =====
// ----------------------------------------------------------------------------
// mbalu_core: single-pass ALU datapath
// Add/subtract with carry, rotates through carry, signed sentinel handling.
// ----------------------------------------------------------------------------
module mbalu_core import mbalu_pkg::*; (
	input  in_beat_t  item,
	input  logic      carry_in,
	input  logic      signed_mode,
	output out_beat_t result
);

	logic [VBITS-1:0] a;
	logic [VBITS-1:0] b;
	logic [VBITS:0]   sum;
	logic [VBITS:0]   diff;
	logic [VBITS-1:0] res;
	logic             cout;
	logic             spec;
	logic             neg;
	logic             ovf;
	logic             arith;

	assign a = item.operand_a[VBITS-1:0];
	assign b = item.operand_b[VBITS-1:0];

	// one wide adder and one wide subtractor, carry in at the bottom
	assign sum  = {1'b0, a} + {1'b0, b} + {{VBITS{1'b0}}, carry_in};
	assign diff = {1'b0, a} - {1'b0, b} - {{VBITS{1'b0}}, carry_in};

	// function select
	always_comb begin
		res   = '0;
		cout  = 1'b0;
		ovf   = 1'b0;
		arith = 1'b0;
		case (item.func)
			FUNC_ADC: begin
				res   = sum[VBITS-1:0];
				cout  = sum[VBITS];
				ovf   = (a[VBITS-1] ~^ b[VBITS-1]) & (a[VBITS-1] ^ res[VBITS-1]);
				arith = 1'b1;
			end
			FUNC_SBC: begin
				res   = diff[VBITS-1:0];
				cout  = diff[VBITS];  // borrow out
				ovf   = (a[VBITS-1] ^ b[VBITS-1]) & (a[VBITS-1] ^ res[VBITS-1]);
				arith = 1'b1;
			end
			FUNC_RCR: begin
				res  = {carry_in, a[VBITS-1:1]};
				cout = a[0];
			end
			FUNC_RCL: begin
				res  = {a[VBITS-2:0], carry_in};
				cout = a[VBITS-1];
			end
			default: begin
				res  = '0;
				cout = 1'b0;
			end
		endcase
	end

	// flags and signed sentinel substitution
	always_comb begin
		result.result_value  = DATA_W'(res);
		result.carry_out     = cout;
		spec                 = 1'b0;
		neg                  = 1'b0;
		if (arith) begin
			if (signed_mode) begin
				result.carry_out = 1'b0;
				if (a == SENTINEL || b == SENTINEL || ovf) begin
					result.result_value = DATA_W'(SENTINEL);
					spec = 1'b1;
					neg  = 1'b1;
				end else if (res == '0) begin
					spec = 1'b1;
				end else begin
					neg = res[VBITS-1];
				end
			end else begin
				spec = (res == '0);
			end
		end
		result.special       = spec;
		result.negative_fill = neg;
	end

endmodule

// ===== hdl/multibyte_add_sub_rotate_alu.sv =====
// ----------------------------------------------------------------------------
// multibyte_add_sub_rotate_alu: multibyte ALU with one carry flag
// Input register, single-pass datapath, result register; carry kept in a flop.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_beat  (in_beat_t)
//  out     | output    | out_valid / out_ready  | out_beat (out_beat_t)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_data (signed_mode)
//
// One beat per cycle sustained while the output is not stalled; out_valid rises once
// an accepted beat has passed the input register, then the result register.
// The carry flag updates as a beat moves into the result register, so the
// next beat in the input register always sees the carry of the one before.
// Reset clears valids, carry flag and signed_mode; cfg_ready is always high.
// A stalled output holds both stages; in_ready drops only when both are full.
module multibyte_add_sub_rotate_alu import mbalu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	in_beat_t  item_s1;
	logic      valid_s1;
	out_beat_t result_s2;
	logic      valid_s2;
	logic      carry_q;
	logic      signed_mode_q;
	out_beat_t core_result;
	logic      s2_free;
	logic      s1_move;

	assign s2_free  = !valid_s2 || out_ready;
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_beat;
		end
	end

	mbalu_core u_core (
		.item        (item_s1),
		.carry_in    (carry_q),
		.signed_mode (signed_mode_q),
		.result      (core_result)
	);

	// result stage and carry flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			carry_q  <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s1_move) begin
				carry_q <= core_result.carry_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = result_s2;

`ifndef NO_ASSERTIONS
	// carry flag tracks the carry of the beat just moved to the result stage
	a_carry_track: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> carry_q == out_beat.carry_out)
		else $error("carry flag does not match delivered carry");

	// a held input beat waits while the result stage is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a beat during stall");

	// negative_fill comes only from signed arithmetic, which clears carry
	a_neg_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.negative_fill |-> !out_beat.carry_out)
		else $error("negative result with carry set");

	// special with negative means the sentinel
	a_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.special && out_beat.negative_fill
		|-> out_beat.result_value == DATA_W'(SENTINEL))
		else $error("special negative result is not the sentinel");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multibyte_add_sub_rotate_alu
// Drives add, subtract and rotate beats through valid/ready, keeps its own
// carry and mode copy to predict every result beat, and compares field by
// field. Runs directed corner cases, then random traffic under several
// pacing patterns in both unsigned and signed mode.
// ----------------------------------------------------------------------------
module testbench import mbalu_pkg::*; ();

	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_PHASES = 8;
	localparam int OPS_PER_PHASE = 112;

	logic      clk;
	logic      arst_n;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_beat = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_beat;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	in_beat_t  pending_ops[$];
	out_beat_t expected_results[$];

	// predictor state
	logic model_carry = 1'b0;
	logic model_signed = 1'b0;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int results_checked = 0;
	int ops_queued = 0;
	int ops_accepted = 0;
	int cfg_writes = 0;
	int cycles = 0;

	multibyte_add_sub_rotate_alu i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ALU prediction; advances the carry copy
	function automatic out_beat_t alu_predict(in_beat_t op);
		logic [VBITS-1:0] a;
		logic [VBITS-1:0] b;
		logic [VBITS-1:0] r;
		logic [VBITS:0]   wide;
		logic             ovf;
		out_beat_t        e;
		a = op.operand_a[VBITS-1:0];
		b = op.operand_b[VBITS-1:0];
		e = '0;
		ovf = 1'b0;
		case (op.func)
			FUNC_RCR: begin
				r = {model_carry, a[VBITS-1:1]};
				e.carry_out = a[0];
			end
			FUNC_RCL: begin
				r = {a[VBITS-2:0], model_carry};
				e.carry_out = a[VBITS-1];
			end
			default: begin
				if (op.func == FUNC_ADC) begin
					wide = {1'b0, a} + {1'b0, b} + {{VBITS{1'b0}}, model_carry};
					r = wide[VBITS-1:0];
					ovf = (a[VBITS-1] == b[VBITS-1]) && (r[VBITS-1] != a[VBITS-1]);
				end else begin
					// top bit of the wide difference is the borrow out
					wide = {1'b0, a} - {1'b0, b} - {{VBITS{1'b0}}, model_carry};
					r = wide[VBITS-1:0];
					ovf = (a[VBITS-1] != b[VBITS-1]) && (r[VBITS-1] != a[VBITS-1]);
				end
				e.carry_out = wide[VBITS];
				if (model_signed) begin
					e.carry_out = 1'b0;
					if (a == SENTINEL || b == SENTINEL || ovf) begin
						r = SENTINEL;
						e.special = 1'b1;
						e.negative_fill = 1'b1;
					end else if (r == '0) begin
						e.special = 1'b1;
					end else begin
						e.negative_fill = r[VBITS-1];
					end
				end else begin
					e.special = (r == '0);
				end
			end
		endcase
		e.result_value[VBITS-1:0] = r;
		model_carry = e.carry_out;
		return e;
	endfunction

	function automatic void queue_op(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		in_beat_t op;
		op.func = f;
		op.operand_a = a;
		op.operand_b = b;
		pending_ops.push_back(op);
		ops_queued++;
	endfunction

	// operand mix biased toward sign and sentinel boundaries
	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2: v = DATA_W'(SENTINEL);
			3: v = DATA_W'(SENTINEL) - DATA_W'(1);
			4: v = DATA_W'($urandom_range(255));
			5: v = -DATA_W'($urandom_range(255));
			6: v = DATA_W'(SENTINEL) + DATA_W'($urandom_range(3));
			default: ;
		endcase
		return v;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_beat <= pending_ops.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// accepted input beats -> expected results
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(alu_predict(in_beat));
			ops_accepted++;
		end
	end

	// config beats update the mode copy
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			model_signed = cfg_data;
			cfg_writes++;
		end
	end

	// result checker
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", out_beat);
				errors++;
			end else begin
				e = expected_results.pop_front();
				results_checked++;
				if (out_beat.result_value !== e.result_value) begin
					$error("result_value: expected %h, got %h", e.result_value,
						out_beat.result_value);
					errors++;
				end
				if (out_beat.carry_out !== e.carry_out) begin
					$error("carry_out: expected %b, got %b", e.carry_out, out_beat.carry_out);
					errors++;
				end
				if (out_beat.special !== e.special) begin
					$error("special: expected %b, got %b", e.special, out_beat.special);
					errors++;
				end
				if (out_beat.negative_fill !== e.negative_fill) begin
					$error("negative_fill: expected %b, got %b", e.negative_fill,
						out_beat.negative_fill);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_mode(logic m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued beat has come back and been checked
	task automatic drain();
		while (results_checked != ops_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	localparam logic [DATA_W-1:0] ALL1 = '1;
	localparam logic [DATA_W-1:0] SNT  = DATA_W'(SENTINEL);
	localparam logic [DATA_W-1:0] MAXP = DATA_W'(SENTINEL) - DATA_W'(1);

	initial begin
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [FUNC_W-1:0] f;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// unsigned corners: zero, carry chain, borrow chain, rotates
		write_mode(1'b0);
		queue_op(FUNC_ADC, '0, '0);
		queue_op(FUNC_ADC, ALL1, 64'd1);
		queue_op(FUNC_ADC, 64'd5, 64'd7);
		queue_op(FUNC_SBC, '0, 64'd1);
		queue_op(FUNC_SBC, 64'd10, 64'd3);
		queue_op(FUNC_SBC, 64'h1234, 64'h1234);
		queue_op(FUNC_ADC, ALL1, ALL1);
		queue_op(FUNC_RCR, 64'd1, '0);
		queue_op(FUNC_RCR, ALL1, ALL1);
		queue_op(FUNC_RCL, SNT, '0);
		queue_op(FUNC_RCL, 64'h5555_5555_5555_5555, '0);
		queue_op(FUNC_SBC, MAXP, SNT);
		drain();

		// signed corners: sentinel operands, overflow, zero, negative
		write_mode(1'b1);
		queue_op(FUNC_ADC, SNT, 64'd1);
		queue_op(FUNC_SBC, 64'd1, SNT);
		queue_op(FUNC_ADC, MAXP, 64'd1);
		queue_op(FUNC_SBC, SNT + 64'd1, 64'd2);
		queue_op(FUNC_ADC, 64'd3, -64'd3);
		queue_op(FUNC_SBC, 64'd2, 64'd9);
		queue_op(FUNC_ADC, 64'd100, 64'd23);
		queue_op(FUNC_RCL, SNT, ALL1);
		queue_op(FUNC_ADC, -64'd1, '0);
		queue_op(FUNC_RCL, SNT, '0);
		queue_op(FUNC_SBC, 64'd1, '0);
		queue_op(FUNC_SBC, -64'd4, 64'd7);
		drain();

		// random traffic: mode toggles, pacing pattern per pair of phases
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 2)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			write_mode(ph[0]);
			for (int n = 0; n < OPS_PER_PHASE; n++) begin
				f = FUNC_W'($urandom_range(3));
				a = pick_operand();
				b = pick_operand();
				// occasionally make b cancel a, so add or subtract gives zero when no carry comes in
				if ($urandom_range(9) == 0)
					b = (f == FUNC_ADC) ? -a : a;
				queue_op(f, a, b);
			end
			drain();
		end

		if (expected_results.size() != 0) begin
			$error("results outstanding at end: expected %0d, got %0d",
				0, expected_results.size());
			errors++;
		end

		$display("%0d ops driven, %0d results checked, %0d mode writes", ops_accepted,
			results_checked, cfg_writes);
		$display("covered add/sub/rotate in unsigned and signed mode under four pacings");
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== multibyte_add_sub_rotate_alu.f =====
hdl/mbalu_pkg.sv
hdl/mbalu_core.sv
hdl/multibyte_add_sub_rotate_alu.sv
tb/testbench.sv
